// File: rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants of the wildcard matcher
// Holds the item kinds, the wildcard character codes and the queue entry
// that travels from the front end to the match engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  // Pattern wildcard characters.
  localparam logic [7:0] CharStar  = 8'd42;
  localparam logic [7:0] CharQuest = 8'd63;

  // Depth of the queue between the front end and the engine.
  localparam int unsigned QueueDepth = 2;

  // Kind of an input item.
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_NAME = 1'b1
  } func_e;

  // One classified item waiting in the queue.
  typedef struct packed {
    func_e      func;
    logic [7:0] chr;
    logic       last;
    logic       is_star;
    logic       is_quest;
  } q_item_t;

  // Control handed from the engine to the result stage.
  typedef struct packed {
    logic valid;
    logic overflow;
  } res_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/gwm_front.sv
// ----------------------------------------------------------------------------
// gwm_front: input acceptance and classification
// Takes input transfers, decodes the item kind and the wildcard flags, and
// holds the classified items in a short queue in front of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             func_i,
  input  wire logic [7:0]       char_code_i,
  input  wire logic             last_i,
  output logic                  q_valid_o,
  output gwm_pkg::q_item_t      q_item_o,
  input  wire logic             q_pop_i
);

  localparam int unsigned CntW = $clog2(gwm_pkg::QueueDepth + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_ptr_q, rd_ptr_q;
  gwm_pkg::q_item_t mem_q [gwm_pkg::QueueDepth];
  gwm_pkg::q_item_t item;
  logic             push;

  // Classify the incoming character once, so the engine gets the wildcard flags ready-made.
  always_comb begin
    item.func     = gwm_pkg::func_e'(func_i);
    item.chr      = char_code_i;
    item.last     = last_i;
    item.is_star  = (char_code_i == gwm_pkg::CharStar);
    item.is_quest = (char_code_i == gwm_pkg::CharQuest);
  end

  // Queue occupancy; a push and a pop may happen in the same cycle.
  assign in_ready_o = (cnt_q != CntW'(gwm_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gwm_engine.sv
// ----------------------------------------------------------------------------
// gwm_engine: pattern store and active position vector
// Writes pattern characters into a row of cells and advances the set of
// active pattern positions by one name character per cycle while fin_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_engine #(
  parameter int unsigned MaxPattern = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire gwm_pkg::q_item_t                q_item_i,
  output logic                                 q_pop_o,
  input  wire logic                            fin_ready_i,
  output gwm_pkg::res_ctrl_t                   fin_ctrl_o,
  output logic [MaxPattern:0]                  fin_vec_o,
  output logic [MaxPattern:0]                  fin_smask_o,
  output logic [$clog2(MaxPattern+1)-1:0]      fin_len_o
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam int unsigned NPos = MaxPattern + 1;

  logic [LenW-1:0]       len_q, len0;
  logic                  closed_q, ovf_q;
  logic [NPos-1:0]       act_q;
  logic [7:0]            chr_q [MaxPattern];
  logic [MaxPattern-1:0] star_q, quest_q;

  logic [MaxPattern-1:0] vmask;
  logic [NPos-1:0]       smask, act_cl, nxt, start_vec;
  logic                  pop, is_load, is_name, wr_ok;

  assign pop     = q_valid_i && fin_ready_i;
  assign q_pop_o = pop;
  assign is_load = pop && (q_item_i.func == gwm_pkg::FUNC_LOAD);
  assign is_name = pop && (q_item_i.func == gwm_pkg::FUNC_NAME);

  assign start_vec = NPos'(1);

  // A closed pattern restarts at position zero on the next load.
  assign len0  = closed_q ? '0 : len_q;
  assign wr_ok = (len0 < LenW'(MaxPattern));

  // Positions inside the current pattern, and the stars among them.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      vmask[i] = (LenW'(i) < len_q);
      smask[i] = star_q[i] && vmask[i];
    end
    smask[MaxPattern] = 1'b0;
  end

  // Star closure: an active star also activates every position through the
  // end of its run of stars. The carry of the add walks each run.
  assign act_cl = act_q | (((act_q & smask) + smask) ^ smask);

  // One step of the position automaton for the current name character.
  always_comb begin
    nxt = '0;
    for (int i = 0; i < MaxPattern; i++) begin
      if (act_cl[i] && vmask[i]) begin
        if (star_q[i]) begin
          nxt[i] = 1'b1;
        end else if (quest_q[i] || (chr_q[i] == q_item_i.chr)) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
  end

  // Hand the final vector of a name to the result stage.
  assign fin_ctrl_o.valid    = is_name && q_item_i.last;
  assign fin_ctrl_o.overflow = ovf_q;
  assign fin_vec_o           = nxt;
  assign fin_smask_o         = smask;
  assign fin_len_o           = len_q;

  // Pattern bookkeeping and the active position vector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      closed_q <= 1'b1;
      ovf_q    <= 1'b0;
      act_q    <= NPos'(1);
    end else if (is_load) begin
      len_q    <= wr_ok ? (len0 + LenW'(1)) : len0;
      ovf_q    <= (ovf_q && !closed_q) || !wr_ok;
      closed_q <= q_item_i.last;
      act_q    <= start_vec;
    end else if (is_name) begin
      act_q <= q_item_i.last ? start_vec : nxt;
    end
  end

  // Pattern cells are written only at the current length, below MaxPattern, and need no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPattern; i++) begin
      if (is_load && wr_ok && (len0 == LenW'(i))) begin
        chr_q[i]   <= q_item_i.chr;
        star_q[i]  <= q_item_i.is_star;
        quest_q[i] <= q_item_i.is_quest;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/gwm_finish.sv
// ----------------------------------------------------------------------------
// gwm_finish: match decision and result register
// Closes the final position vector over trailing stars, picks the bit at
// the pattern end and holds the result until the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_finish #(
  parameter int unsigned MaxPattern = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire gwm_pkg::res_ctrl_t              ctrl_i,
  input  wire logic [MaxPattern:0]             vec_i,
  input  wire logic [MaxPattern:0]             smask_i,
  input  wire logic [$clog2(MaxPattern+1)-1:0] len_i,
  output logic                                 ready_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 matched_o,
  output logic                                 pattern_overflow_o
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  logic                fin_valid_q, fin_ovf_q;
  logic [MaxPattern:0] vec_q, smask_q, vec_cl;
  logic [LenW-1:0]     len_q;
  logic                out_valid_q, matched_q, ovf_out_q;
  logic                out_load;

  assign out_load = !out_valid_q || out_ready_i;
  assign ready_o  = !fin_valid_q || out_load;

  // Trailing stars may still carry an active position to the pattern end.
  assign vec_cl = vec_q | (((vec_q & smask_q) + smask_q) ^ smask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        fin_valid_q <= ctrl_i.valid;
      end
      if (out_load) begin
        out_valid_q <= fin_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ready_o && ctrl_i.valid) begin
      vec_q     <= vec_i;
      smask_q   <= smask_i;
      len_q     <= len_i;
      fin_ovf_q <= ctrl_i.overflow;
    end
    if (out_load && fin_valid_q) begin
      matched_q <= vec_cl[len_q];
      ovf_out_q <= fin_ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

endmodule

`default_nettype wire

// File: rtl/glob_wildcard_match_top.sv
// Throughput: one item per cycle, load or name character, while neither the
//   queue nor the output stalls; set by the single position-vector update in the engine.
// Path: after its last character's transfer, a name's result passes the
//   queue, the final-vector register and the output register; output stalls hold it.
// Reset: empty queue and pipeline, empty closed pattern, clear overflow flag,
//   start position active; pattern cells are not cleared.
// ----------------------------------------------------------------------------
// glob_wildcard_match_top: whole-string wildcard matcher
// Loads a pattern with '*' and '?' wildcards and matches streamed names.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_match_top #(
  parameter int unsigned MaxPattern = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            matched_o,
  output logic            pattern_overflow_o
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  logic                q_valid, q_pop, fin_ready;
  gwm_pkg::q_item_t    q_item;
  gwm_pkg::res_ctrl_t  fin_ctrl;
  logic [MaxPattern:0] fin_vec, fin_smask;
  logic [LenW-1:0]     fin_len;

  // Front end: accept and classify, queue in front of the engine.
  gwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  // Engine: pattern store and position automaton.
  gwm_engine #(
    .MaxPattern (MaxPattern)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .fin_ready_i (fin_ready),
    .fin_ctrl_o  (fin_ctrl),
    .fin_vec_o   (fin_vec),
    .fin_smask_o (fin_smask),
    .fin_len_o   (fin_len)
  );

  // Result stage: final decision and output register.
  gwm_finish #(
    .MaxPattern (MaxPattern)
  ) u_finish (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (fin_ctrl),
    .vec_i              (fin_vec),
    .smask_i            (fin_smask),
    .len_i              (fin_len),
    .ready_o            (fin_ready),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

endmodule

`default_nettype wire
